FILE: rtl/jpt_pkg.sv
// shared types, constants and lookup tables of the joint posterior top-n block
package jpt_pkg;

    localparam int HAPS     = 16;
    localparam int UMIS     = 16;
    localparam int KEEP     = 16;
    localparam int SUM_W    = 21;
    localparam int WGT_W    = 17;
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 21;

    localparam logic signed [31:0] NEG_INF  = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] NEG_MIN1 = 32'sh8000_0001;

    localparam logic [2:0] OP_JOINT     = 3'd0;
    localparam logic [2:0] OP_UMI_PRIOR = 3'd1;
    localparam logic [2:0] OP_HAP_SCORE = 3'd2;
    localparam logic [2:0] OP_UMI_SCORE = 3'd3;
    localparam logic [2:0] OP_COMPUTE   = 3'd4;

    localparam logic [1:0] REG_HAP_COUNT  = 2'd0;
    localparam logic [1:0] REG_UMI_COUNT  = 2'd1;
    localparam logic [1:0] REG_KEEP_COUNT = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         hap_index;
        logic [3:0]         umi_index;
        logic signed [31:0] log_value;
    } item_t;

    typedef struct packed {
        logic [3:0]         hap_id;
        logic [3:0]         umi_id;
        logic [3:0]         rank;
        logic [16:0]        weight;
        logic signed [31:0] read_loglik;
        logic               none_finite;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_DRAIN, ST_EXP, ST_NSET,
        ST_NORM, ST_LNDIV, ST_WSTART, ST_WDIV, ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_issue;
        logic post_init;
        logic exp_step;
        logic norm_load;
        logic norm_shift;
        logic ln_start;
        logic ll_load;
        logic w_start;
        logic w_capture;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic exp_rank_done;
        logic rank_last;
        logic none;
        logic norm_done;
        logic div_done;
        logic fill;
    } stat_t;

    function automatic logic [4:0] clamp_count(logic [4:0] v, logic [4:0] hi);
        logic [4:0] c;
        c = (v == 5'd0) ? 5'd1 : v;
        return (c > hi) ? hi : c;
    endfunction

    function automatic logic [16:0] exp_int(logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_a(logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd61565;
            4'd2:  r = 17'd57835;
            4'd3:  r = 17'd54331;
            4'd4:  r = 17'd51039;
            4'd5:  r = 17'd47947;
            4'd6:  r = 17'd45042;
            4'd7:  r = 17'd42313;
            4'd8:  r = 17'd39750;
            4'd9:  r = 17'd37341;
            4'd10: r = 17'd35079;
            4'd11: r = 17'd32953;
            4'd12: r = 17'd30957;
            4'd13: r = 17'd29081;
            4'd14: r = 17'd27319;
            4'd15: r = 17'd25664;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_b(logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd65280;
            4'd2:  r = 17'd65026;
            4'd3:  r = 17'd64772;
            4'd4:  r = 17'd64520;
            4'd5:  r = 17'd64268;
            4'd6:  r = 17'd64018;
            4'd7:  r = 17'd63768;
            4'd8:  r = 17'd63520;
            4'd9:  r = 17'd63272;
            4'd10: r = 17'd63025;
            4'd11: r = 17'd62781;
            4'd12: r = 17'd62535;
            4'd13: r = 17'd62291;
            4'd14: r = 17'd62048;
            4'd15: r = 17'd61806;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] ln_tab(logic [3:0] n);
        logic [15:0] r;
        unique case (n)
            4'd0:  r = 16'd0;
            4'd1:  r = 16'd3973;
            4'd2:  r = 16'd7719;
            4'd3:  r = 16'd11262;
            4'd4:  r = 16'd14624;
            4'd5:  r = 16'd17821;
            4'd6:  r = 16'd20870;
            4'd7:  r = 16'd23783;
            4'd8:  r = 16'd26573;
            4'd9:  r = 16'd29248;
            4'd10: r = 16'd31818;
            4'd11: r = 16'd34292;
            4'd12: r = 16'd36675;
            4'd13: r = 16'd38975;
            4'd14: r = 16'd41196;
            4'd15: r = 16'd43345;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/joint_posterior_top_n.sv
// top level of the joint posterior top-n block
//
//   channel   dir   signals                      transaction
//   item      in    start, busy, item            start && !busy at a clock edge
//   result    out   valid, result                one cycle per strobe, no stall
//   config    in    wr_en, wr_index, wr_data     wr_en at a clock edge
//
// load items do not raise busy. a compute item keeps busy high through the scan,
// one pair per cycle, the drain, four steps per rank for exp, the first a table
// lookup and the rest multiplies, the normalize shifts, and the bit-serial
// divider for the log and for each filled rank.
// reset sets the configuration to its defaults, empties the top list and clears all control state.
// results leave a register and are never held back by the receiver.
module joint_posterior_top_n (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  jpt_pkg::item_t    item,
    output logic              valid,
    output jpt_pkg::result_t  result,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [4:0]        wr_data
);

    jpt_pkg::cmd_t  cmd;
    jpt_pkg::stat_t stat;

    jpt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    jpt_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cmd      (cmd),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .stat     (stat),
        .result   (result),
        .valid    (valid)
    );

`ifndef NO_ASSERTIONS
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.last |=> !valid)
        else $error("result after the final rank");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.last |=> busy)
        else $error("read ended before its final rank");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.none_finite |->
            result.weight == 17'd0 && result.read_loglik == jpt_pkg::NEG_INF)
        else $error("nonzero weight on an all-infinite read");
`endif

endmodule

FILE: rtl/jpt_div.sv
// restoring divider, one quotient bit per cycle
module jpt_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [jpt_pkg::DIV_NUM_W-1:0]    num,
    input  logic [jpt_pkg::DIV_DEN_W-1:0]    den,
    output logic                             done,
    output logic [jpt_pkg::DIV_NUM_W-1:0]    quot
);

    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    logic [5:0]                       cnt_reg, cnt_next;
    logic [jpt_pkg::DIV_DEN_W-1:0]    rem_reg, rem_next;
    logic [jpt_pkg::DIV_NUM_W-1:0]    q_reg, q_next;
    logic [jpt_pkg::DIV_DEN_W-1:0]    den_reg;
    logic [jpt_pkg::DIV_DEN_W:0]      trial;
    logic                             fits;

    assign trial = {rem_reg, q_reg[jpt_pkg::DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'(jpt_pkg::DIV_NUM_W);
            rem_next = '0;
            q_next   = num;
        end
        else if (run_reg)
        begin
            rem_next = fits ? jpt_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                            : trial[jpt_pkg::DIV_DEN_W-1:0];
            q_next   = {q_reg[jpt_pkg::DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/jpt_datapath.sv
// stores, pair scan with sorted top list, exp, ln and weight datapath
module jpt_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  jpt_pkg::item_t    item,
    input  jpt_pkg::cmd_t     cmd,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [4:0]        wr_data,
    output jpt_pkg::stat_t    stat,
    output jpt_pkg::result_t  result,
    output logic              valid
);

    // configuration
    logic [4:0] hap_cnt_reg, umi_cnt_reg, keep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hap_cnt_reg <= 5'd16;
            umi_cnt_reg <= 5'd16;
            keep_reg    <= 5'd4;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                jpt_pkg::REG_HAP_COUNT:
                    hap_cnt_reg <= jpt_pkg::clamp_count(wr_data, 5'(jpt_pkg::HAPS));
                jpt_pkg::REG_UMI_COUNT:
                    umi_cnt_reg <= jpt_pkg::clamp_count(wr_data, 5'(jpt_pkg::UMIS));
                jpt_pkg::REG_KEEP_COUNT:
                    keep_reg <= jpt_pkg::clamp_count(wr_data, 5'(jpt_pkg::KEEP));
                default: ;
            endcase
        end
    end

    // stores
    logic signed [31:0] jmem [jpt_pkg::HAPS*jpt_pkg::UMIS];
    logic signed [31:0] umi_prior [jpt_pkg::UMIS];
    logic signed [31:0] hap_score [jpt_pkg::HAPS];
    logic signed [31:0] umi_score [jpt_pkg::UMIS];

    logic [3:0]         h_cnt_reg, u_cnt_reg;
    logic               v1_reg, v2_reg;
    logic signed [31:0] g_reg, et_reg, su_reg, sh_reg;
    logic [3:0]         h1_reg, u1_reg, h2_reg, u2_reg;
    logic signed [31:0] pv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && item.opcode == jpt_pkg::OP_JOINT)
            jmem[{item.umi_index, item.hap_index}] <= item.log_value;
        if (cmd.scan_issue)
            g_reg <= jmem[{u_cnt_reg, h_cnt_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && item.opcode == jpt_pkg::OP_UMI_PRIOR)
            umi_prior[item.umi_index] <= item.log_value;
        if (cmd.load && item.opcode == jpt_pkg::OP_HAP_SCORE)
            hap_score[item.hap_index] <= item.log_value;
        if (cmd.load && item.opcode == jpt_pkg::OP_UMI_SCORE)
            umi_score[item.umi_index] <= item.log_value;
        if (cmd.scan_issue)
        begin
            et_reg <= umi_prior[u_cnt_reg];
            su_reg <= umi_score[u_cnt_reg];
            sh_reg <= hap_score[h_cnt_reg];
            h1_reg <= h_cnt_reg;
            u1_reg <= u_cnt_reg;
        end
        h2_reg <= h1_reg;
        u2_reg <= u1_reg;
    end

    // pair counters, haplotype outer and umi inner
    logic u_wrap;
    assign u_wrap = (5'(u_cnt_reg) == umi_cnt_reg - 5'd1);
    assign stat.scan_last = u_wrap && (5'(h_cnt_reg) == hap_cnt_reg - 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_cnt_reg <= '0;
            u_cnt_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            if (cmd.scan_init)
            begin
                h_cnt_reg <= '0;
                u_cnt_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                u_cnt_reg <= u_wrap ? 4'd0 : u_cnt_reg + 4'd1;
                if (u_wrap)
                    h_cnt_reg <= h_cnt_reg + 4'd1;
            end
        end
    end

    assign stat.pipe_busy = v1_reg || v2_reg;

    // pair value with minus infinity and saturation
    logic               any_inf;
    logic signed [33:0] wide;
    logic signed [31:0] pv_next;

    always_comb
    begin
        any_inf = (g_reg == jpt_pkg::NEG_INF) || (et_reg == jpt_pkg::NEG_INF)
               || (su_reg == jpt_pkg::NEG_INF) || (sh_reg == jpt_pkg::NEG_INF);
        wide = 34'(g_reg) + 34'(et_reg) + 34'(su_reg) + 34'(sh_reg);
        if (any_inf)
            pv_next = jpt_pkg::NEG_INF;
        else if (wide > 34'sd2147483647)
            pv_next = jpt_pkg::POS_MAX;
        else if (wide < -34'sd2147483647)
            pv_next = jpt_pkg::NEG_MIN1;
        else
            pv_next = wide[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            pv_reg <= pv_next;
    end

    // sorted top list, ties keep the earlier pair ahead
    logic signed [31:0] bval_reg [jpt_pkg::KEEP];
    logic [3:0]         bhap_reg [jpt_pkg::KEEP];
    logic [3:0]         bumi_reg [jpt_pkg::KEEP];
    logic [jpt_pkg::KEEP-1:0] bvld_reg;
    logic signed [31:0] bval_next [jpt_pkg::KEEP];
    logic [3:0]         bhap_next [jpt_pkg::KEEP];
    logic [3:0]         bumi_next [jpt_pkg::KEEP];
    logic [jpt_pkg::KEEP-1:0] bvld_next;
    logic [jpt_pkg::KEEP-1:0] ge;
    logic               ins;

    assign ins = v2_reg && (pv_reg != jpt_pkg::NEG_INF);

    always_comb
    begin
        for (int i = 0; i < jpt_pkg::KEEP; i++)
        begin
            ge[i]        = bvld_reg[i] && (bval_reg[i] >= pv_reg);
            bval_next[i] = bval_reg[i];
            bhap_next[i] = bhap_reg[i];
            bumi_next[i] = bumi_reg[i];
            bvld_next[i] = bvld_reg[i];
        end
        if (ins)
        begin
            if (!ge[0])
            begin
                bval_next[0] = pv_reg;
                bhap_next[0] = h2_reg;
                bumi_next[0] = u2_reg;
                bvld_next[0] = 1'b1;
            end
            for (int i = 1; i < jpt_pkg::KEEP; i++)
            begin
                if (!ge[i])
                begin
                    if (ge[i-1])
                    begin
                        bval_next[i] = pv_reg;
                        bhap_next[i] = h2_reg;
                        bumi_next[i] = u2_reg;
                        bvld_next[i] = 1'b1;
                    end
                    else
                    begin
                        bval_next[i] = bval_reg[i-1];
                        bhap_next[i] = bhap_reg[i-1];
                        bumi_next[i] = bumi_reg[i-1];
                        bvld_next[i] = bvld_reg[i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bvld_reg <= '0;
        else if (cmd.scan_init)
            bvld_reg <= '0;
        else
            bvld_reg <= bvld_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < jpt_pkg::KEEP; i++)
        begin
            bval_reg[i] <= bval_next[i];
            bhap_reg[i] <= bhap_next[i];
            bumi_reg[i] <= bumi_next[i];
        end
    end

    // rank sequencing and exp
    logic [3:0]                 rank_reg;
    logic [1:0]                 step_reg;
    logic signed [31:0]         maxv_reg;
    logic                       none_reg;
    logic [16:0]                acc_reg;
    logic [15:0]                f_reg;
    logic [16:0]                e_mem [jpt_pkg::KEEP];
    logic [jpt_pkg::SUM_W-1:0]  sum_reg;
    logic                       rank_last;
    logic signed [32:0]         delta;
    logic [16:0]                e_start;
    logic [16:0]                factor;
    logic [33:0]                prod;
    logic [34:0]                rounded;
    logic [16:0]                acc_next;

    assign rank_last = (5'(rank_reg) == keep_reg - 5'd1);
    assign stat.rank_last     = rank_last;
    assign stat.exp_rank_done = (step_reg == 2'd3);
    assign stat.none          = none_reg;
    assign stat.fill          = !none_reg && bvld_reg[rank_reg];

    always_comb
    begin
        delta = 33'(maxv_reg) - 33'(bval_reg[rank_reg]);
        if (!bvld_reg[rank_reg] || delta[32:20] != '0 || delta[19:16] > 4'd11)
            e_start = '0;
        else
            e_start = jpt_pkg::exp_int(delta[19:16]);
        unique case (step_reg)
            2'd1:    factor = jpt_pkg::exp_a(f_reg[15:12]);
            2'd2:    factor = jpt_pkg::exp_b(f_reg[11:8]);
            default: factor = 17'd65536 - 17'(f_reg[7:0]);
        endcase
        prod     = acc_reg * factor;
        rounded  = 35'(prod) + 35'd32768;
        acc_next = rounded[32:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.post_init)
        begin
            rank_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.exp_step)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
                rank_reg <= rank_last ? 4'd0 : rank_reg + 4'd1;
        end
        else if (cmd.emit)
            rank_reg <= rank_last ? 4'd0 : rank_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post_init)
        begin
            maxv_reg <= bval_reg[0];
            none_reg <= !bvld_reg[0];
            sum_reg  <= '0;
        end
        else if (cmd.exp_step)
        begin
            if (step_reg == 2'd0)
            begin
                acc_reg <= e_start;
                f_reg   <= delta[15:0];
            end
            else
                acc_reg <= acc_next;
            if (step_reg == 2'd3)
            begin
                e_mem[rank_reg] <= acc_next;
                sum_reg <= sum_reg + jpt_pkg::SUM_W'(acc_next);
            end
        end
    end

    // normalize sum to [1, 2) for the log
    logic [jpt_pkg::SUM_W-1:0] m_reg;
    logic [2:0]                k_reg;

    assign stat.norm_done = (m_reg[jpt_pkg::SUM_W-1:17] == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.norm_load)
        begin
            m_reg <= sum_reg;
            k_reg <= '0;
        end
        else if (cmd.norm_shift)
        begin
            m_reg <= m_reg >> 1;
            k_reg <= k_reg + 3'd1;
        end
    end

    // shared divider for the log fraction and the weights
    logic [3:0]                    j_sel;
    logic [16:0]                   base;
    logic [jpt_pkg::DIV_NUM_W-1:0] div_num;
    logic [jpt_pkg::DIV_DEN_W-1:0] div_den;
    logic [jpt_pkg::DIV_NUM_W-1:0] quot;
    logic                          div_done;
    logic [16:0]                   e_sel;

    assign j_sel = m_reg[15:12];
    assign base  = {1'b1, j_sel, 12'd0};
    assign e_sel = e_mem[rank_reg];

    always_comb
    begin
        if (cmd.ln_start)
        begin
            div_num = jpt_pkg::DIV_NUM_W'({m_reg[11:0], 16'd0})
                    + jpt_pkg::DIV_NUM_W'(base >> 1);
            div_den = jpt_pkg::DIV_DEN_W'(base);
        end
        else
        begin
            div_num = jpt_pkg::DIV_NUM_W'({e_sel, 16'd0})
                    + jpt_pkg::DIV_NUM_W'(sum_reg >> 1);
            div_den = sum_reg;
        end
    end

    jpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.ln_start || cmd.w_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    assign stat.div_done = div_done;

    // read likelihood and weight
    logic [19:0]        ln_u;
    logic signed [33:0] ll_w;
    logic signed [31:0] ll_reg;
    logic [16:0]        w_reg;

    assign ln_u = 20'(k_reg) * 20'd45426 + 20'(jpt_pkg::ln_tab(j_sel)) + 20'(quot[16:0]);
    assign ll_w = 34'(maxv_reg) + $signed(34'(ln_u));

    always_ff @(posedge clk)
    begin
        if (cmd.norm_load && none_reg)
            ll_reg <= jpt_pkg::NEG_INF;
        else if (cmd.ll_load)
            ll_reg <= (ll_w > 34'sd2147483647) ? jpt_pkg::POS_MAX : ll_w[31:0];
        if (cmd.w_capture)
            w_reg <= quot[16:0];
    end

    // result register
    jpt_pkg::result_t res_reg;
    logic             valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.hap_id      <= stat.fill ? bhap_reg[rank_reg] : 4'd0;
            res_reg.umi_id      <= stat.fill ? bumi_reg[rank_reg] : 4'd0;
            res_reg.rank        <= rank_reg;
            res_reg.weight      <= stat.fill ? w_reg : 17'd0;
            res_reg.read_loglik <= ll_reg;
            res_reg.none_finite <= none_reg;
            res_reg.last        <= rank_last;
        end
    end

    assign result = res_reg;
    assign valid  = valid_reg;

endmodule

FILE: rtl/jpt_ctrl.sv
// sequencing state machine for load, scan, drain, exp, normalize, log, weight and emit phases
module jpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2:0]      opcode,
    input  jpt_pkg::stat_t  stat,
    output jpt_pkg::cmd_t   cmd,
    output logic            busy
);

    jpt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jpt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jpt_pkg::ST_IDLE:
                if (start && opcode == jpt_pkg::OP_COMPUTE)
                    state_next = jpt_pkg::ST_SCAN;
            jpt_pkg::ST_SCAN:
                if (stat.scan_last)
                    state_next = jpt_pkg::ST_DRAIN;
            jpt_pkg::ST_DRAIN:
                if (!stat.pipe_busy)
                    state_next = jpt_pkg::ST_EXP;
            jpt_pkg::ST_EXP:
                if (stat.exp_rank_done && stat.rank_last)
                    state_next = jpt_pkg::ST_NSET;
            jpt_pkg::ST_NSET:
                state_next = stat.none ? jpt_pkg::ST_WSTART : jpt_pkg::ST_NORM;
            jpt_pkg::ST_NORM:
                if (stat.norm_done)
                    state_next = jpt_pkg::ST_LNDIV;
            jpt_pkg::ST_LNDIV:
                if (stat.div_done)
                    state_next = jpt_pkg::ST_WSTART;
            jpt_pkg::ST_WSTART:
                state_next = stat.fill ? jpt_pkg::ST_WDIV : jpt_pkg::ST_EMIT;
            jpt_pkg::ST_WDIV:
                if (stat.div_done)
                    state_next = jpt_pkg::ST_EMIT;
            jpt_pkg::ST_EMIT:
                state_next = stat.rank_last ? jpt_pkg::ST_IDLE : jpt_pkg::ST_WSTART;
            default:
                state_next = jpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            jpt_pkg::ST_IDLE:
            begin
                cmd.load      = start && opcode < jpt_pkg::OP_COMPUTE;
                cmd.scan_init = start && opcode == jpt_pkg::OP_COMPUTE;
            end
            jpt_pkg::ST_SCAN:   cmd.scan_issue = 1'b1;
            jpt_pkg::ST_DRAIN:  cmd.post_init  = !stat.pipe_busy;
            jpt_pkg::ST_EXP:    cmd.exp_step   = 1'b1;
            jpt_pkg::ST_NSET:   cmd.norm_load  = 1'b1;
            jpt_pkg::ST_NORM:
            begin
                cmd.norm_shift = !stat.norm_done;
                cmd.ln_start   = stat.norm_done;
            end
            jpt_pkg::ST_LNDIV:  cmd.ll_load   = stat.div_done;
            jpt_pkg::ST_WSTART: cmd.w_start   = stat.fill;
            jpt_pkg::ST_WDIV:   cmd.w_capture = stat.div_done;
            jpt_pkg::ST_EMIT:   cmd.emit      = 1'b1;
            default: ;
        endcase
    end

    assign busy = (state_reg != jpt_pkg::ST_IDLE);

endmodule

FILE: dv/tb_joint_posterior_top_n.sv
// testbench for the joint posterior top-n block: random loads and computes against a predictor
`timescale 1ns / 100ps

module tb_joint_posterior_top_n;

    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          SETTLE      = 40;
    localparam logic [2:0]  OP_SPARE    = 3'd5;   // 5..7 are unused codes

    localparam longint unsigned EXP_WHOLE[12] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    localparam longint unsigned EXP_COARSE[16] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
        39750, 37341, 35079, 32953, 30957, 29081, 27319, 25664};
    localparam longint unsigned EXP_FINE[16] = '{
        65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
        63520, 63272, 63025, 62781, 62535, 62291, 62048, 61806};
    localparam longint unsigned LN_STEP[16] = '{
        0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
        26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345};

    class posterior_board;
        int                  joint[256];
        int                  umi_pri[16];
        int                  hap_sc[16];
        int                  umi_sc[16];
        int                  hap_n = 16;
        int                  umi_n = 16;
        int                  keep_n = 4;
        jpt_pkg::result_t    expected_q[$];
        int                  errors = 0;

        function int clamp_reg(logic [4:0] v);
            if (v == 0)
                return 1;
            return (v > 16) ? 16 : int'(v);
        endfunction

        function void set_reg(logic [1:0] idx, logic [4:0] v);
            if (idx == jpt_pkg::REG_HAP_COUNT)
                hap_n = clamp_reg(v);
            else if (idx == jpt_pkg::REG_UMI_COUNT)
                umi_n = clamp_reg(v);
            else if (idx == jpt_pkg::REG_KEEP_COUNT)
                keep_n = clamp_reg(v);
        endfunction

        function longint unsigned qmul(longint unsigned a, longint unsigned b);
            return (a * b + 32768) >> 16;
        endfunction

        function longint unsigned exp_fix(longint d);
            longint unsigned mag;
            longint unsigned n;
            longint unsigned f;
            longint unsigned r;
            mag = (d < 0) ? longint'(-d) : 0;
            n = mag >> 16;
            f = mag & 16'hffff;
            if (n > 11)
                return 0;
            r = EXP_WHOLE[n];
            r = qmul(r, EXP_COARSE[f >> 12]);
            r = qmul(r, EXP_FINE[(f >> 8) & 15]);
            r = qmul(r, 65536 - (f & 255));
            return r;
        endfunction

        function longint ln_fix(longint unsigned total);
            int              p;
            int              k;
            longint unsigned m;
            longint unsigned j;
            longint unsigned base;
            p = 16;
            while (p < 40 && (total >> (p + 1)) != 0)
                p++;
            k = p - 16;
            m = total >> k;
            j = (m >> 12) & 15;
            base = 65536 + 4096 * j;
            return longint'(k) * 45426 + longint'(LN_STEP[j])
                + longint'(((((m - base) & 16'hffff) * 65536) + base / 2) / base);
        endfunction

        function void rank_read();
            int                  pv[256];
            int                  bv[16];
            int                  bh[16];
            int                  bu[16];
            longint unsigned     e[16];
            longint unsigned     total;
            longint              x;
            longint              ll;
            int                  maxv;
            int                  bi;
            bit                  found;
            bit                  none;
            bit                  fill;
            logic [31:0]         code;
            jpt_pkg::result_t    r;
            for (int i = 0; i < 256; i++)
                pv[i] = jpt_pkg::NEG_INF;
            for (int k = 0; k < hap_n; k++)
                for (int b = 0; b < umi_n; b++) begin
                    if (joint[b*16+k] != jpt_pkg::NEG_INF && umi_pri[b] != jpt_pkg::NEG_INF
                        && umi_sc[b] != jpt_pkg::NEG_INF && hap_sc[k] != jpt_pkg::NEG_INF)
                    begin
                        x = longint'(joint[b*16+k]) + umi_pri[b] + umi_sc[b] + hap_sc[k];
                        if (x > 64'sd2147483647)
                            x = 64'sd2147483647;
                        if (x < -64'sd2147483647)
                            x = -64'sd2147483647;
                        pv[k*16+b] = int'(x);
                    end
                end
            // repeated max search, strict compare keeps the earliest pair on ties
            for (int t = 0; t < 16; t++) begin
                found = 0;
                bi = 0;
                bv[t] = jpt_pkg::NEG_INF;
                bh[t] = 0;
                bu[t] = 0;
                if (t < keep_n)
                    for (int k = 0; k < hap_n; k++)
                        for (int b = 0; b < umi_n; b++)
                            if (pv[k*16+b] != jpt_pkg::NEG_INF
                                && (!found || pv[k*16+b] > bv[t])) begin
                                bv[t] = pv[k*16+b];
                                bi = k * 16 + b;
                                found = 1;
                            end
                if (found) begin
                    bh[t] = bi / 16;
                    bu[t] = bi % 16;
                    pv[bi] = jpt_pkg::NEG_INF;
                end
            end
            maxv = bv[0];
            none = (maxv == jpt_pkg::NEG_INF);
            total = 0;
            for (int t = 0; t < keep_n; t++) begin
                e[t] = (bv[t] == jpt_pkg::NEG_INF) ? 0
                     : exp_fix(longint'(bv[t]) - longint'(maxv));
                total += e[t];
            end
            if (none)
                code = jpt_pkg::NEG_INF;
            else begin
                ll = longint'(maxv) + ln_fix(total);
                if (ll > 64'sd2147483647)
                    ll = 64'sd2147483647;
                code = ll[31:0];
            end
            for (int t = 0; t < keep_n; t++) begin
                fill = !none && bv[t] != jpt_pkg::NEG_INF;
                r.hap_id      = fill ? bh[t][3:0] : 4'd0;
                r.umi_id      = fill ? bu[t][3:0] : 4'd0;
                r.rank        = t[3:0];
                r.weight      = fill ? 17'((e[t] * 65536 + total / 2) / total) : 17'd0;
                r.read_loglik = code;
                r.none_finite = none;
                r.last        = (t + 1 == keep_n);
                expected_q.push_back(r);
            end
        endfunction

        function void note_item(jpt_pkg::item_t it);
            case (it.opcode)
                jpt_pkg::OP_JOINT:     joint[{it.umi_index, it.hap_index}] = it.log_value;
                jpt_pkg::OP_UMI_PRIOR: umi_pri[it.umi_index] = it.log_value;
                jpt_pkg::OP_HAP_SCORE: hap_sc[it.hap_index] = it.log_value;
                jpt_pkg::OP_UMI_SCORE: umi_sc[it.umi_index] = it.log_value;
                jpt_pkg::OP_COMPUTE:   rank_read();
                default:               ;
            endcase
        endfunction

        function void field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(jpt_pkg::result_t got);
            jpt_pkg::result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            field("hap_id", want.hap_id, got.hap_id);
            field("umi_id", want.umi_id, got.umi_id);
            field("rank", want.rank, got.rank);
            field("weight", want.weight, got.weight);
            field("read_loglik", want.read_loglik, got.read_loglik);
            field("none_finite", want.none_finite, got.none_finite);
            field("last", want.last, got.last);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    jpt_pkg::item_t      item;
    logic                valid;
    jpt_pkg::result_t    result;
    logic                wr_en;
    logic [1:0]          wr_index;
    logic [4:0]          wr_data;
    int                  cycles = 0;

    posterior_board sb = new();

    joint_posterior_top_n u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .valid    (valid),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[joint_posterior_top_n] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_log();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return jpt_pkg::NEG_INF;
        else if (sel < 12)
            return jpt_pkg::POS_MAX;
        else if (sel < 15)
            return jpt_pkg::NEG_MIN1;
        else if (sel < 25)
            return $urandom();
        else if (sel < 55)
            return ($urandom_range(0, 16) - 8) << 14;  // coarse grid, many ties
        return $urandom_range(0, 24 << 16) - (12 << 16);
    endfunction

    function automatic jpt_pkg::item_t rand_item();
        jpt_pkg::item_t it;
        int             sel;
        sel = $urandom_range(0, 99);
        it.hap_index = 4'($urandom_range(0, 15));
        it.umi_index = 4'($urandom_range(0, 15));
        it.log_value = rand_log();
        if (sel < 16)
            it.opcode = jpt_pkg::OP_COMPUTE;
        else if (sel < 20)
            it.opcode = 3'(OP_SPARE + $urandom_range(0, 2));
        else
            it.opcode = 3'($urandom_range(0, 3));
        return it;
    endfunction

    // hold start until the block takes the transaction, then maybe idle
    task automatic send(jpt_pkg::item_t it);
        int gap;
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load(logic [2:0] op, int h, int u, logic [31:0] v);
        jpt_pkg::item_t it;
        it.opcode    = op;
        it.hap_index = h[3:0];
        it.umi_index = u[3:0];
        it.log_value = v;
        send(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(logic [4:0] hv, logic [4:0] uv, logic [4:0] kv);
        logic [4:0] vals[3];
        vals = '{hv, uv, kv};
        drain();
        for (int i = 0; i < 3; i++) begin
            wr_en    <= 1'b1;
            wr_index <= i[1:0];
            wr_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(i[1:0], vals[i]);
        end
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [4:0] phase_cfg[9][3];
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        phase_cfg = '{'{5'd0, 5'd0, 5'd0}, '{5'd31, 5'd31, 5'd31}, '{5'd16, 5'd16, 5'd16},
                      '{5'd3, 5'd5, 5'd16}, '{5'd1, 5'd16, 5'd8}, '{5'd16, 5'd1, 5'd2},
                      '{5'd17, 5'd2, 5'd5}, '{5'd7, 5'd9, 5'd1}, '{5'd16, 5'd16, 5'd4}};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every store entry is written before the first compute
        for (int h = 0; h < 16; h++)
            for (int u = 0; u < 16; u++)
                load(jpt_pkg::OP_JOINT, h, u, rand_log());
        for (int i = 0; i < 16; i++) begin
            load(jpt_pkg::OP_UMI_PRIOR, 0, i, rand_log());
            load(jpt_pkg::OP_HAP_SCORE, i, 0, rand_log());
            load(jpt_pkg::OP_UMI_SCORE, 0, i, rand_log());
        end

        // directed: reset settings, saturation both ways, unused codes, all infinite
        load(jpt_pkg::OP_COMPUTE, 0, 0, 0);
        load(jpt_pkg::OP_JOINT, 0, 0, jpt_pkg::POS_MAX);
        load(jpt_pkg::OP_UMI_PRIOR, 0, 0, jpt_pkg::POS_MAX);
        load(jpt_pkg::OP_HAP_SCORE, 0, 0, jpt_pkg::POS_MAX);
        load(jpt_pkg::OP_UMI_SCORE, 15, 0, jpt_pkg::POS_MAX);
        load(jpt_pkg::OP_COMPUTE, 15, 15, 32'hffff_ffff);
        load(jpt_pkg::OP_JOINT, 15, 15, jpt_pkg::NEG_MIN1);
        load(jpt_pkg::OP_UMI_PRIOR, 0, 15, jpt_pkg::NEG_MIN1);
        load(jpt_pkg::OP_HAP_SCORE, 15, 0, jpt_pkg::NEG_MIN1);
        load(jpt_pkg::OP_UMI_SCORE, 0, 15, jpt_pkg::NEG_MIN1);
        load(jpt_pkg::OP_COMPUTE, 0, 0, 0);
        for (int i = 0; i < 3; i++)
            load(3'(OP_SPARE + i), 15, 15, 32'hffff_ffff);
        for (int i = 0; i < 16; i++)
            load(jpt_pkg::OP_HAP_SCORE, i, 0, jpt_pkg::NEG_INF);
        load(jpt_pkg::OP_COMPUTE, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            load(jpt_pkg::OP_HAP_SCORE, i, 0, ($urandom_range(0, 8) - 4) << 14);
        load(jpt_pkg::OP_COMPUTE, 0, 0, 0);

        for (int p = 0; p < 9; p++) begin
            configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            for (int n = 0; n < 14; n++)
                send(rand_item());
        end
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[joint_posterior_top_n] OK");
        else begin
            if (sb.expected_q.size() != 0)
                $error("%0d expected results never arrived", sb.expected_q.size());
            $display("[joint_posterior_top_n] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/jpt_pkg.sv
rtl/jpt_div.sv
rtl/jpt_datapath.sv
rtl/jpt_ctrl.sv
rtl/joint_posterior_top_n.sv
dv/tb_joint_posterior_top_n.sv
